// ===== src/tosq_pkg.sv =====
package tosq_pkg;

   // fixed field widths of the channels
   localparam int STAMP_W = 48;
   localparam int DATA_W  = 64;
   localparam int WIDE_W  = 64;
   localparam int OCC_W   = 6;
   localparam int TOTAL_W = 32;
   localparam int WIN_W   = 16;

   typedef logic [OCC_W-1:0]   occ_type;
   typedef logic [WIDE_W-1:0]  wide_type;
   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [WIN_W-1:0]   window_type;
   typedef logic [TOTAL_W-1:0] total_type;

   // command codes
   localparam logic [1:0] CMD_ADD_SAMPLE   = 2'd0;
   localparam logic [1:0] CMD_ADD_FENCE    = 2'd1;
   localparam logic [1:0] CMD_REMOVE_FENCE = 2'd2;
   localparam logic [1:0] CMD_POP          = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_LATE          = 3'd1;
   localparam logic [2:0] ST_FENCE_EXISTS  = 3'd2;
   localparam logic [2:0] ST_FENCE_MISSING = 3'd3;
   localparam logic [2:0] ST_FULL          = 3'd4;
   localparam logic [2:0] ST_NOTHING       = 3'd5;

   localparam logic [2:0] FENCE_KIND   = 3'd7;
   localparam window_type WINDOW_RESET = 16'd100;

   typedef struct packed {
      logic [1:0]         command;
      logic [2:0]         sample_kind;
      logic [STAMP_W-1:0] stamp;
      logic [DATA_W-1:0]  sample_data;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               item_valid;
      logic [2:0]         out_kind;
      logic [STAMP_W-1:0] out_stamp;
      logic [DATA_W-1:0]  out_data;
      logic               last;
      logic [OCC_W-1:0]   occupancy;
      logic [TOTAL_W-1:0] late_total;
      logic [TOTAL_W-1:0] added_total;
      logic [OCC_W-1:0]   deepest;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic compare;
      logic apply;
      logic scan;
      logic pop_none;
      logic pop_start;
      logic emit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_pop;
      logic take_head;
      logic cnt_zero;
      logic remain_one;
      logic slot_free;
   } dp_status_type;

endpackage

// ===== src/tosq_ctrl.sv =====
module tosq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tosq_pkg::dp_status_type dp_status,
   output tosq_pkg::ctrl_cmd_type  dp_cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CMP    = 6'b000010,
      S_APPLY  = 6'b000100,
      S_SCAN   = 6'b001000,
      S_POPEND = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            dp_cmd.accept = req_valid;
            if (req_valid) state_in = S_CMP;
         end
         S_CMP: begin
            dp_cmd.compare = 1'b1;
            state_in = dp_status.is_pop ? S_SCAN : S_APPLY;
         end
         S_APPLY: begin
            if (dp_status.slot_free) begin
               dp_cmd.apply = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            dp_cmd.scan = 1'b1;
            if (!dp_status.take_head) state_in = S_POPEND;
         end
         S_POPEND: begin
            if (!dp_status.cnt_zero) begin
               dp_cmd.pop_start = 1'b1;
               state_in = S_EMIT;
            end else if (dp_status.slot_free) begin
               dp_cmd.pop_none = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (dp_status.slot_free) begin
               dp_cmd.emit = 1'b1;
               if (dp_status.remain_one) state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== src/tosq_datapath.sv =====
module tosq_datapath #(
   parameter int QUEUE_DEPTH = 32,
   parameter int STAMP_BITS  = 48,
   parameter int DATA_BITS   = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tosq_pkg::req_type       req_item,
   input  tosq_pkg::window_type    window,
   input  tosq_pkg::ctrl_cmd_type  dp_cmd,
   output tosq_pkg::dp_status_type dp_status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tosq_pkg::rsp_type       rsp_item
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // sorted cell chain, entry 0 is the head
   logic [STAMP_BITS-1:0] stamp_ff [QUEUE_DEPTH];
   logic [2:0]            kind_ff  [QUEUE_DEPTH];
   logic [DATA_BITS-1:0]  data_ff  [QUEUE_DEPTH];
   logic [STAMP_BITS-1:0] stamp_in [QUEUE_DEPTH];
   logic [2:0]            kind_in  [QUEUE_DEPTH];
   logic [DATA_BITS-1:0]  data_in  [QUEUE_DEPTH];

   // neighbor taps for shifting
   logic [STAMP_BITS-1:0] stamp_up [QUEUE_DEPTH];
   logic [2:0]            kind_up  [QUEUE_DEPTH];
   logic [DATA_BITS-1:0]  data_up  [QUEUE_DEPTH];
   logic [STAMP_BITS-1:0] stamp_dn [QUEUE_DEPTH];
   logic [2:0]            kind_dn  [QUEUE_DEPTH];
   logic [DATA_BITS-1:0]  data_dn  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] lt_below;

   // latched request
   logic [1:0]            req_cmd_ff;
   logic [2:0]            req_kind_ff;
   logic [STAMP_BITS-1:0] req_stamp_ff;
   logic [DATA_BITS-1:0]  req_data_ff;
   tosq_pkg::wide_type    req_stamp_wide;

   // per-cell compare flags
   logic [QUEUE_DEPTH-1:0] lt_c, eq_c, take_c;
   logic [QUEUE_DEPTH-1:0] lt_ff, take_ff, take_in;
   logic                   dup_ff;

   // control state
   logic [CNT_W-1:0]          fill_ff, fill_in;
   logic [CNT_W-1:0]          peak_ff, peak_in;
   logic [CNT_W-1:0]          scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0]          remain_ff, remain_in;
   logic [STAMP_BITS-1:0]     last_pop_ff, last_pop_in;
   tosq_pkg::total_type       late_ff, late_in;
   tosq_pkg::total_type       added_ff, added_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   tosq_pkg::rsp_type         rsp_ff, rsp_in;

   // apply decision
   logic [2:0] dec_status;
   logic       dec_ins, dec_rem, dec_late, dec_count;
   logic       is_pop;
   logic       slot_free;
   tosq_pkg::wide_type head_wide;

   assign req_stamp_wide = tosq_pkg::wide_type'(req_item.stamp);
   assign is_pop         = (req_cmd_ff == tosq_pkg::CMD_POP);
   assign slot_free      = !rsp_valid_ff || rsp_ready;
   assign head_wide      = tosq_pkg::wide_type'(stamp_ff[0]);

   // request latch; fences and removes use the fence kind
   always_ff @(posedge clock) begin
      if (dp_cmd.accept) begin
         req_cmd_ff   <= req_item.command;
         req_kind_ff  <= (req_item.command == tosq_pkg::CMD_ADD_SAMPLE) ?
                         req_item.sample_kind : tosq_pkg::FENCE_KIND;
         req_stamp_ff <= req_stamp_wide[STAMP_BITS-1:0];
         req_data_ff  <= (req_item.command == tosq_pkg::CMD_ADD_SAMPLE) ?
                         req_item.sample_data[DATA_BITS-1:0] : '0;
      end
   end

   // per-cell compares and shift taps
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic                  held;
      logic [STAMP_BITS-1:0] diff;
      assign held = (CNT_W'(g) < fill_ff);
      assign diff = stamp_ff[g] - stamp_ff[0];
      assign lt_c[g] = held && ((stamp_ff[g] < req_stamp_ff) ||
                       ((stamp_ff[g] == req_stamp_ff) && (kind_ff[g] < req_kind_ff)));
      assign eq_c[g] = held && (stamp_ff[g] == req_stamp_ff) && (kind_ff[g] == req_kind_ff);
      assign take_c[g] = held && (kind_ff[g] != tosq_pkg::FENCE_KIND) &&
                         (diff <= STAMP_BITS'(window));
      if (g == 0) begin : g_head
         assign stamp_up[g] = req_stamp_ff;
         assign kind_up[g]  = req_kind_ff;
         assign data_up[g]  = req_data_ff;
         assign lt_below[g] = 1'b1;
      end else begin : g_body
         assign stamp_up[g] = stamp_ff[g-1];
         assign kind_up[g]  = kind_ff[g-1];
         assign data_up[g]  = data_ff[g-1];
         assign lt_below[g] = lt_ff[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
         assign stamp_dn[g] = stamp_ff[g];
         assign kind_dn[g]  = kind_ff[g];
         assign data_dn[g]  = data_ff[g];
      end else begin : g_inner
         assign stamp_dn[g] = stamp_ff[g+1];
         assign kind_dn[g]  = kind_ff[g+1];
         assign data_dn[g]  = data_ff[g+1];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.compare) begin
         lt_ff  <= lt_c;
         dup_ff <= |eq_c;
      end
   end

   // decision for add and remove, in the order of the checks
   always_comb begin
      dec_status = tosq_pkg::ST_OK;
      dec_ins    = 1'b0;
      dec_rem    = 1'b0;
      dec_late   = 1'b0;
      dec_count  = 1'b0;
      if (req_cmd_ff == tosq_pkg::CMD_REMOVE_FENCE) begin
         if (dup_ff) dec_rem = 1'b1;
         else        dec_status = tosq_pkg::ST_FENCE_MISSING;
      end else if ((req_cmd_ff == tosq_pkg::CMD_ADD_FENCE) && dup_ff) begin
         dec_status = tosq_pkg::ST_FENCE_EXISTS;
      end else if (req_stamp_ff < last_pop_ff) begin
         dec_status = tosq_pkg::ST_LATE;
         dec_late   = 1'b1;
      end else if (dup_ff) begin
         dec_count  = 1'b1;
      end else if (fill_ff >= CNT_W'(QUEUE_DEPTH)) begin
         dec_status = tosq_pkg::ST_FULL;
      end else begin
         dec_ins    = 1'b1;
         dec_count  = 1'b1;
      end
   end

   // cell chain next values: insert, remove, pop shift
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         stamp_in[i] = stamp_ff[i];
         kind_in[i]  = kind_ff[i];
         data_in[i]  = data_ff[i];
         if (dp_cmd.apply && dec_ins && !lt_ff[i]) begin
            if (lt_below[i]) begin
               stamp_in[i] = req_stamp_ff;
               kind_in[i]  = req_kind_ff;
               data_in[i]  = req_data_ff;
            end else begin
               stamp_in[i] = stamp_up[i];
               kind_in[i]  = kind_up[i];
               data_in[i]  = data_up[i];
            end
         end else if ((dp_cmd.apply && dec_rem && !lt_ff[i]) || dp_cmd.emit) begin
            stamp_in[i] = stamp_dn[i];
            kind_in[i]  = kind_dn[i];
            data_in[i]  = data_dn[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
      kind_ff  <= kind_in;
      data_ff  <= data_in;
   end

   // counters, scan, result register
   always_comb begin
      fill_in      = fill_ff;
      peak_in      = peak_ff;
      late_in      = late_ff;
      added_in     = added_ff;
      last_pop_in  = last_pop_ff;
      scan_cnt_in  = scan_cnt_ff;
      remain_in    = remain_ff;
      take_in      = take_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (dp_cmd.compare) begin
         take_in     = take_c;
         scan_cnt_in = '0;
      end
      // count the leading run of poppable entries
      if (dp_cmd.scan && take_ff[0]) begin
         take_in     = take_ff >> 1;
         scan_cnt_in = scan_cnt_ff + 1'b1;
      end
      if (dp_cmd.pop_start) begin
         fill_in   = fill_ff - scan_cnt_ff;
         remain_in = scan_cnt_ff;
      end

      if (dp_cmd.apply) begin
         if (dec_late)  late_in  = late_ff + 1'b1;
         if (dec_count) added_in = added_ff + 1'b1;
         if (dec_ins) begin
            fill_in = fill_ff + 1'b1;
            if (fill_in > peak_ff) peak_in = fill_in;
         end
         if (dec_rem) fill_in = fill_ff - 1'b1;
      end

      if (dp_cmd.apply || dp_cmd.pop_none || dp_cmd.emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = dp_cmd.apply ? dec_status :
                              (dp_cmd.pop_none ? tosq_pkg::ST_NOTHING : tosq_pkg::ST_OK);
         rsp_in.item_valid  = 1'b0;
         rsp_in.out_kind    = '0;
         rsp_in.out_stamp   = '0;
         rsp_in.out_data    = '0;
         rsp_in.last        = 1'b1;
         rsp_in.occupancy   = tosq_pkg::occ_type'(fill_in);
         rsp_in.late_total  = late_in;
         rsp_in.added_total = added_in;
         rsp_in.deepest     = tosq_pkg::occ_type'(peak_in);
         if (dp_cmd.emit) begin
            rsp_in.item_valid = 1'b1;
            rsp_in.out_kind   = kind_ff[0];
            rsp_in.out_stamp  = head_wide[tosq_pkg::STAMP_W-1:0];
            rsp_in.out_data   = tosq_pkg::data_type'(data_ff[0]);
            rsp_in.last       = (remain_ff == CNT_W'(1));
            remain_in         = remain_ff - 1'b1;
            last_pop_in       = stamp_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         peak_ff      <= '0;
         late_ff      <= '0;
         added_ff     <= '0;
         last_pop_ff  <= '0;
         scan_cnt_ff  <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         peak_ff      <= peak_in;
         late_ff      <= late_in;
         added_ff     <= added_in;
         last_pop_ff  <= last_pop_in;
         scan_cnt_ff  <= scan_cnt_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      take_ff <= take_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign dp_status.is_pop     = is_pop;
   assign dp_status.take_head  = take_ff[0];
   assign dp_status.cnt_zero   = (scan_cnt_ff == '0);
   assign dp_status.remain_one = (remain_ff == CNT_W'(1));
   assign dp_status.slot_free  = slot_free;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("fill count above depth");

   a_peak_cover: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= fill_ff)
      else $error("peak below fill count");

   a_emit_remain: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit |-> remain_ff != '0)
      else $error("emit with no item left in run");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.pop_start |-> (scan_cnt_ff <= fill_ff) && (scan_cnt_ff != '0))
      else $error("pop run length out of range");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.apply || dp_cmd.pop_none || dp_cmd.emit) |-> slot_free)
      else $error("result loaded over a waiting item");

endmodule

// ===== src/timestamp_ordered_sample_queue.sv =====
// Timestamp-ordered sample queue.
// req channel (req_valid/req_ready/req_item): add sample, add fence, remove
//   fence or pop; one item is taken at a time, req_ready is high when idle.
// rsp channel (rsp_valid/rsp_ready/rsp_item): one result item per add or
//   remove, one per popped sample for a pop (last marks the final one), or
//   one "nothing popped" item.
// csr channel (csr_valid/csr_ready/csr_wdata): correlate window, always ready.
// Entries sit in a sorted chain of cells; every cell compares with the new
// key in parallel and the whole chain shifts by one position at once.
// Add and remove: accept, compare, apply; the result is registered at the
//   apply, and the next item is taken only once the previous one is done.
// Pop of n samples: compare, count the run serially, then one result per
//   cycle as the head is shifted out, while the receiver takes each one.
// Reset empties the queue, clears counters and last popped stamp, and sets
//   the window to 100. A stalled receiver holds the result register; the
//   controller waits before loading the next result, nothing is dropped.
module timestamp_ordered_sample_queue #(
   parameter int QUEUE_DEPTH = 32,
   parameter int STAMP_BITS  = 48,
   parameter int DATA_BITS   = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tosq_pkg::req_type    req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tosq_pkg::rsp_type    rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  tosq_pkg::window_type csr_wdata
);

   tosq_pkg::window_type    window_ff, window_in;
   tosq_pkg::ctrl_cmd_type  dp_cmd;
   tosq_pkg::dp_status_type dp_status;

   // correlate window register
   assign csr_ready = 1'b1;
   assign window_in = csr_valid ? csr_wdata : window_ff;

   always_ff @(posedge clock) begin
      if (reset) window_ff <= tosq_pkg::WINDOW_RESET;
      else       window_ff <= window_in;
   end

   tosq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   tosq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .STAMP_BITS  (STAMP_BITS),
      .DATA_BITS   (DATA_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .window    (window_ff),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
